// ===== design/pwft_pkg.sv =====
// Package for the priority wildcard flow table.
// Item types, rule record, response codes and controller commands.
// Used by every module of the block; depends on nothing.
package pwft_pkg;

   localparam int unsigned TableDepthDefault = 16;

   typedef enum logic [1:0] {
      ST_LOOKUP   = 2'd0,
      ST_INSERTED = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   typedef struct packed {
      logic        func;
      logic [15:0] flow_id;
      logic [15:0] rule_priority;
      logic [3:0]  action_code;
      logic [15:0] action_option;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [1:0]  mac_any;
      logic [15:0] ether_kind;
      logic [7:0]  ip_proto;
      logic [63:0] ip_pair;
      logic [31:0] port_pair;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [15:0] match_flow_id;
      logic [3:0]  match_action;
      logic [15:0] match_option;
   } rsp_type;

   typedef struct packed {
      logic [15:0] prio;
      logic [15:0] flow_id;
      logic [3:0]  action;
      logic [15:0] option;
      logic [47:0] dmac;
      logic [47:0] smac;
      logic [1:0]  mac_any;
      logic [15:0] ether_kind;
      logic [7:0]  ip_proto;
      logic [63:0] ip_pair;
      logic [31:0] port_pair;
   } rule_type;

   typedef enum logic [1:0] {
      RK_MISS = 2'd0,
      RK_HIT  = 2'd1,
      RK_OK   = 2'd2,
      RK_FULL = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic         load;      // capture request, set index
      logic         rd;        // read slot at index
      logic         rd_prev;   // read slot at index - 1
      logic         wr_shift;  // write read data at index
      logic         wr_new;    // write new rule at index
      logic         idx_inc;
      logic         idx_dec;
      logic         count_inc;
      logic         emit;
      rsp_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic idx_zero;
      logic idx_end;
      logic match;
      logic prio_le;
   } stat_type;

endpackage

// ===== design/pwft_datapath.sv =====
// Datapath of the flow table: request register, rule memory, walk index,
// rule count, match compare and the response register.
// Depends on pwft_pkg; driven by pwft_ctrl commands.
module pwft_datapath #(
   parameter int unsigned TABLE_DEPTH = pwft_pkg::TableDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  pwft_pkg::req_type req,
   input  pwft_pkg::cmd_type cmd,
   output pwft_pkg::stat_type stat,
   output logic             rsp_valid,
   output pwft_pkg::rsp_type rsp
);

   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

   pwft_pkg::req_type  req_ff;
   pwft_pkg::rule_type mem [TABLE_DEPTH];
   pwft_pkg::rule_type rd_data_ff;
   pwft_pkg::rule_type new_rule;
   pwft_pkg::rsp_type  rsp_ff, rsp_in;
   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in, idx_m1;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          rsp_valid_ff;
   logic          match;

   assign idx_m1  = idx_ff - CW'(1);
   assign rd_addr = cmd.rd_prev ? idx_m1[IW-1:0] : idx_ff[IW-1:0];
   assign wr_addr = idx_ff[IW-1:0];

   always_comb begin
      new_rule.prio       = req_ff.rule_priority;
      new_rule.flow_id    = req_ff.flow_id;
      new_rule.action     = req_ff.action_code;
      new_rule.option     = req_ff.action_option;
      new_rule.dmac       = req_ff.dst_mac;
      new_rule.smac       = req_ff.src_mac;
      new_rule.mac_any    = req_ff.mac_any;
      new_rule.ether_kind = req_ff.ether_kind;
      new_rule.ip_proto   = req_ff.ip_proto;
      new_rule.ip_pair    = req_ff.ip_pair;
      new_rule.port_pair  = req_ff.port_pair;
   end

   // zero rule field is a wildcard; MACs use the mac_any flags
   always_comb begin
      match = (rd_data_ff.mac_any[0] || rd_data_ff.dmac == req_ff.dst_mac)
         && (rd_data_ff.mac_any[1] || rd_data_ff.smac == req_ff.src_mac)
         && (rd_data_ff.ether_kind == '0 || rd_data_ff.ether_kind == req_ff.ether_kind)
         && (rd_data_ff.ip_proto == '0 || rd_data_ff.ip_proto == req_ff.ip_proto)
         && (rd_data_ff.ip_pair[63:32] == '0
             || rd_data_ff.ip_pair[63:32] == req_ff.ip_pair[63:32])
         && (rd_data_ff.ip_pair[31:0] == '0
             || rd_data_ff.ip_pair[31:0] == req_ff.ip_pair[31:0])
         && (rd_data_ff.port_pair[31:16] == '0
             || rd_data_ff.port_pair[31:16] == req_ff.port_pair[31:16])
         && (rd_data_ff.port_pair[15:0] == '0
             || rd_data_ff.port_pair[15:0] == req_ff.port_pair[15:0]);
   end

   always_comb begin
      stat.full     = (count_ff == DepthC);
      stat.idx_zero = (idx_ff == '0);
      stat.idx_end  = (idx_ff == count_ff);
      stat.match    = match;
      stat.prio_le  = (rd_data_ff.prio <= req_ff.rule_priority);
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = (req.func == pwft_pkg::FUNC_INSERT) ? count_ff : '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end
      count_in = cmd.count_inc ? count_ff + CW'(1) : count_ff;
   end

   always_comb begin
      rsp_in = '0;
      case (cmd.kind)
         pwft_pkg::RK_HIT: begin
            rsp_in.status        = pwft_pkg::ST_LOOKUP;
            rsp_in.hit           = 1'b1;
            rsp_in.match_flow_id = rd_data_ff.flow_id;
            rsp_in.match_action  = rd_data_ff.action;
            rsp_in.match_option  = rd_data_ff.option;
         end
         pwft_pkg::RK_OK:   rsp_in.status = pwft_pkg::ST_INSERTED;
         pwft_pkg::RK_FULL: rsp_in.status = pwft_pkg::ST_REJECTED;
         default:           rsp_in.status = pwft_pkg::ST_LOOKUP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd || cmd.rd_prev) rd_data_ff <= mem[rd_addr];
      if (cmd.wr_shift) begin
         mem[wr_addr] <= rd_data_ff;
      end else if (cmd.wr_new) begin
         mem[wr_addr] <= new_rule;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC) else $error("rule count above depth");
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe held");
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == pwft_pkg::ST_INSERTED
      |-> count_ff == $past(count_ff) + CW'(1)) else $error("insert without count");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= count_ff) else $error("walk index past count");

endmodule

// ===== design/pwft_ctrl.sv =====
// Controller of the flow table: walks stored rules one slot at a time
// for lookup (forward) and insert (backward shift). Depends on pwft_pkg.
module pwft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              func,
   input  pwft_pkg::stat_type stat,
   output pwft_pkg::cmd_type  cmd,
   output logic              busy
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LK_RD  = 5'b00010,
      S_LK_CHK = 5'b00100,
      S_IN_RD  = 5'b01000,
      S_IN_CHK = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = pwft_pkg::RK_MISS;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (func == pwft_pkg::FUNC_INSERT) ? S_IN_RD : S_LK_RD;
            end
         end
         S_LK_RD: begin
            if (stat.idx_end) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_LK_CHK;
            end
         end
         S_LK_CHK: begin
            if (stat.match) begin
               cmd.emit = 1'b1;
               cmd.kind = pwft_pkg::RK_HIT;
               state_in = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_LK_RD;
            end
         end
         S_IN_RD: begin
            if (stat.full) begin
               cmd.emit = 1'b1;
               cmd.kind = pwft_pkg::RK_FULL;
               state_in = S_IDLE;
            end else if (stat.idx_zero) begin
               cmd.wr_new    = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.emit      = 1'b1;
               cmd.kind      = pwft_pkg::RK_OK;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = S_IN_CHK;
            end
         end
         S_IN_CHK: begin
            // move lower-or-equal priority rules down one slot
            if (stat.prio_le) begin
               cmd.wr_shift = 1'b1;
               cmd.idx_dec  = 1'b1;
               state_in     = S_IN_RD;
            end else begin
               cmd.wr_new    = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.emit      = 1'b1;
               cmd.kind      = pwft_pkg::RK_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_no_dual_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_shift && cmd.wr_new)) else $error("two writes in one cycle");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_LK_RD || state_ff == S_IN_RD)
      else $error("load did not start a walk");
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE) else $error("result without return to idle");

endmodule

// ===== design/priority_wildcard_flow_table.sv =====
// Priority wildcard flow table: insert rules in priority order and look up
// packet headers against them. Instantiates pwft_ctrl and pwft_datapath.
//
// Usage:
//   Request channel: drive req_data and raise start; the item is taken at the
//   edge where start is high and busy is low. busy stays high until the
//   result has been produced.
//   Result channel: rsp_valid is high for one cycle with rsp_data; the
//   receiver cannot stall it and must take it in that cycle.
//   Lookup: walks stored rules from highest priority, each slot by a memory
//   read, then a compare. The strobe comes at the first matching slot on a
//   hit, or after the last stored rule has been compared on a miss.
//   Insert: walks from the tail and moves each rule of lower or equal
//   priority down one slot, then writes the new rule into the freed slot;
//   a full table answers rejected.
//   The next item can be taken in the cycle the result strobe is shown.
//   The single-port rule memory sets the pace: each slot needs its own read.
//   Reset: the rule count goes to zero; no memory clearing is needed, as
//   only slots below the count are read.
module priority_wildcard_flow_table #(
   parameter int unsigned TABLE_DEPTH = pwft_pkg::TableDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pwft_pkg::req_type req_data,
   output logic              rsp_valid,
   output pwft_pkg::rsp_type rsp_data
);

   pwft_pkg::cmd_type  cmd;
   pwft_pkg::stat_type stat;

   pwft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_data.func),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   pwft_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

// ===== tb/pwft_checker.sv =====
// Checker for the priority wildcard flow table: watches both channels,
// predicts each result from a private rule table and compares field by field.
// Depends on pwft_pkg.
`timescale 1ns / 1ps
module pwft_checker #(
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  pwft_pkg::req_type req,
   input  logic              rsp_valid,
   input  pwft_pkg::rsp_type rsp,
   output int                fail_count,
   output int                pending
);

   pwft_pkg::rule_type rules[DEPTH];
   int unsigned n_rules;
   pwft_pkg::rsp_type want_q[$];

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] exp);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
      fail_count++;
   endtask

   function automatic logic fld_ok(input logic [63:0] r, input logic [63:0] p);
      return r == 0 || r == p;
   endfunction

   function automatic logic rule_hits(input pwft_pkg::rule_type r,
                                      input pwft_pkg::req_type p);
      if (!r.mac_any[0] && r.dmac != p.dst_mac) return 1'b0;
      if (!r.mac_any[1] && r.smac != p.src_mac) return 1'b0;
      return fld_ok(64'(r.ether_kind), 64'(p.ether_kind))
         && fld_ok(64'(r.ip_proto), 64'(p.ip_proto))
         && fld_ok(64'(r.ip_pair[63:32]), 64'(p.ip_pair[63:32]))
         && fld_ok(64'(r.ip_pair[31:0]), 64'(p.ip_pair[31:0]))
         && fld_ok(64'(r.port_pair[31:16]), 64'(p.port_pair[31:16]))
         && fld_ok(64'(r.port_pair[15:0]), 64'(p.port_pair[15:0]));
   endfunction

   task automatic apply_item(input pwft_pkg::req_type p);
      pwft_pkg::rsp_type o;
      int unsigned pos;
      pwft_pkg::rule_type nr;
      o = '0;
      if (p.func == pwft_pkg::FUNC_INSERT) begin
         if (n_rules >= DEPTH) begin
            o.status = pwft_pkg::ST_REJECTED;
         end else begin
            pos = 0;
            while (pos < n_rules && rules[pos].prio > p.rule_priority) pos++;
            for (int i = int'(n_rules); i > int'(pos); i--) rules[i] = rules[i-1];
            nr = '{p.rule_priority, p.flow_id, p.action_code, p.action_option,
                   p.dst_mac, p.src_mac, p.mac_any, p.ether_kind, p.ip_proto,
                   p.ip_pair, p.port_pair};
            rules[pos] = nr;
            n_rules++;
            o.status = pwft_pkg::ST_INSERTED;
         end
      end else begin
         o.status = pwft_pkg::ST_LOOKUP;
         for (int i = 0; i < int'(n_rules); i++) begin
            if (rule_hits(rules[i], p)) begin
               o.hit = 1'b1;
               o.match_flow_id = rules[i].flow_id;
               o.match_action = rules[i].action;
               o.match_option = rules[i].option;
               break;
            end
         end
      end
      want_q.push_back(o);
   endtask

   assign pending = want_q.size();

   always @(posedge clock) begin
      pwft_pkg::rsp_type w;
      if (reset) begin
         n_rules = 0;
         fail_count = 0;
         want_q.delete();
      end else begin
         // result of an older item is checked before a new item is predicted
         if (rsp_valid) begin
            if (want_q.size() == 0) begin
               report("unexpected result", 64'(rsp), 64'd0);
            end else begin
               w = want_q.pop_front();
               if (rsp.status !== w.status)
                  report("status", 64'(rsp.status), 64'(w.status));
               if (rsp.hit !== w.hit) report("hit", 64'(rsp.hit), 64'(w.hit));
               if (rsp.match_flow_id !== w.match_flow_id)
                  report("flow_id", 64'(rsp.match_flow_id), 64'(w.match_flow_id));
               if (rsp.match_action !== w.match_action)
                  report("action", 64'(rsp.match_action), 64'(w.match_action));
               if (rsp.match_option !== w.match_option)
                  report("option", 64'(rsp.match_option), 64'(w.match_option));
            end
         end
         if (start && !busy) apply_item(req);
      end
   end
endmodule

// ===== tb/tb_priority_wildcard_flow_table.sv =====
// Testbench top for the priority wildcard flow table: drives inserts and
// lookups with random gaps, and gives the verdict. Depends on pwft_pkg,
// pwft_checker and the block.
`timescale 1ns / 1ps
module tb_priority_wildcard_flow_table;

   localparam int unsigned DEPTH = 16;
   localparam int IdleLimit = 2000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   pwft_pkg::req_type req;
   logic              rsp_valid;
   pwft_pkg::rsp_type rsp;
   int                fail_count;
   int                pending;
   int                idle_cycles;

   // small pools so that lookups hit stored rules often
   logic [47:0] mac_pool[4];
   logic [31:0] ip_pool[4];
   logic [15:0] port_pool[4];

   priority_wildcard_flow_table #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock, .reset, .start, .busy, .req_data(req), .rsp_valid, .rsp_data(rsp));

   pwft_checker #(.DEPTH(DEPTH)) u_chk (
      .clock, .reset, .start, .busy, .req, .rsp_valid, .rsp, .fail_count, .pending);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic pwft_pkg::req_type rand_item(input logic f, input int mode);
      pwft_pkg::req_type r;
      logic [319:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      r = raw[$bits(pwft_pkg::req_type)-1:0];
      r.func = f;
      if (mode == 0) begin
         // well-formed: fields drawn from pools, many wildcards in rules
         r.dst_mac = mac_pool[$urandom_range(0, 3)];
         r.src_mac = mac_pool[$urandom_range(0, 3)];
         r.ether_kind = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'h0800;
         r.ip_proto = ($urandom_range(0, 2) == 0) ? 8'h0 : 8'd6;
         r.ip_pair = {($urandom_range(0, 1) ? 32'h0 : ip_pool[$urandom_range(0, 3)]),
                      ($urandom_range(0, 1) ? 32'h0 : ip_pool[$urandom_range(0, 3)])};
         r.port_pair = {($urandom_range(0, 1) ? 16'h0 : port_pool[$urandom_range(0, 3)]),
                        ($urandom_range(0, 1) ? 16'h0 : port_pool[$urandom_range(0, 3)])};
         r.rule_priority = 16'($urandom_range(0, 7));
         if (f == pwft_pkg::FUNC_LOOKUP) begin
            if (r.ether_kind == 0) r.ether_kind = 16'h0800;
            if (r.ip_proto == 0) r.ip_proto = 8'd6;
         end
      end
      return r;
   endfunction

   // start stays high after the accepting edge; gap or drain lowers it
   task automatic send(input pwft_pkg::req_type r);
      req <= r;
      start <= 1'b1;
      @(posedge clock iff !busy);
   endtask

   task automatic gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      pwft_pkg::req_type r;
      reset = 1;
      start = 0;
      req = '0;
      foreach (mac_pool[i]) mac_pool[i] = {16'($urandom), $urandom};
      foreach (ip_pool[i]) ip_pool[i] = $urandom;
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
      mac_pool[0] = '1;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: lookup into empty table, all-wildcard rule, extremes
      r = '0; send(r);
      r = '1; r.func = pwft_pkg::FUNC_LOOKUP; send(r);
      r = '0; r.func = pwft_pkg::FUNC_INSERT; r.mac_any = 2'b11; r.flow_id = 16'hFFFF;
      r.action_code = 4'hF; r.action_option = 16'hFFFF; r.rule_priority = 0; send(r);
      r = '1; r.func = pwft_pkg::FUNC_LOOKUP; send(r);
      r = '1; r.func = pwft_pkg::FUNC_INSERT; r.mac_any = 2'b00; r.flow_id = 16'h1234;
      send(r);
      r = '1; r.func = pwft_pkg::FUNC_LOOKUP; send(r);
      r.ip_pair[0] = 1'b0; send(r);
      // equal priorities: newer first
      r = '0; r.func = pwft_pkg::FUNC_INSERT; r.mac_any = 2'b11; r.rule_priority = 16'hFFFF;
      r.flow_id = 16'h00A1; r.ip_proto = 8'd17; send(r);
      r.flow_id = 16'h00A2; send(r);
      r = '0; r.func = pwft_pkg::FUNC_LOOKUP; r.ip_proto = 8'd17; r.mac_any = 2'b00; send(r);
      // fill to full, then rejected insert
      for (int i = 0; i < 13; i++) begin
         r = rand_item(pwft_pkg::FUNC_INSERT, 1);
         send(r);
      end
      r = rand_item(pwft_pkg::FUNC_LOOKUP, 1); send(r);
      drain();
      // restart from a fresh table is not possible; keep reset single.
      // random phase: table stays full, lookups exercise full depth
      for (int i = 0; i < 600; i++) begin
         r = rand_item(($urandom_range(0, 9) == 0) ? pwft_pkg::FUNC_INSERT
                                                   : pwft_pkg::FUNC_LOOKUP,
                       ($urandom_range(0, 4) == 0) ? 1 : 0);
         send(r);
         if (i == 300) drain();
         gap();
      end
      drain();
      repeat (2 + 2 * DEPTH + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
